/* src/tac_pkg.sv */
// shared types, constants and the power table builder of the thermal anemometer conversion
// no dependencies
`default_nettype none

package tac_pkg;

    localparam int SAMPLE_W = 10;
    localparam int TEMP_W   = 15;
    localparam int SPEED_W  = 16;
    localparam int CLASS_W  = 4;
    localparam int AIR_W    = 2;
    localparam int CFG_W    = 10;

    typedef logic [SPEED_W-1:0] t_speed;

    typedef struct packed {
        logic [SAMPLE_W-1:0] therm_sample;
        logic [SAMPLE_W-1:0] wind_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic [SPEED_W-1:0]       speed_tenth_mph;
        logic [CLASS_W-1:0]       beaufort_class;
        logic [AIR_W-1:0]         air_condition;
    } t_out_item;

    localparam logic [CFG_W-1:0] ZERO_OFFSET_RST = 10'd200;

    // beaufort upper bounds in 0.1 mph
    localparam int BF_N = 11;
    localparam t_speed BF_BOUND [BF_N] = '{
        16'd30, 16'd70, 16'd120, 16'd170, 16'd240, 16'd300,
        16'd380, 16'd460, 16'd540, 16'd630, 16'd720
    };
    localparam t_speed BF_CALM = 16'd10;

    // m/s per 0.1 mph, scaled by 1e6
    localparam int MS_SCALE = 44704;
    localparam t_speed AIR_LIM_GOOD   = SPEED_W'((500000 + MS_SCALE - 1) / MS_SCALE);
    localparam t_speed AIR_LIM_NORMAL = SPEED_W'((1000000 + MS_SCALE - 1) / MS_SCALE);
    localparam t_speed AIR_LIM_BAD    = SPEED_W'((1500000 + MS_SCALE - 1) / MS_SCALE);

    localparam logic [AIR_W-1:0] AIR_GOOD     = 2'd0;
    localparam logic [AIR_W-1:0] AIR_NORMAL   = 2'd1;
    localparam logic [AIR_W-1:0] AIR_BAD      = 2'd2;
    localparam logic [AIR_W-1:0] AIR_VERY_BAD = 2'd3;

    localparam int     Q_BITS   = 30;
    localparam longint PWR_ONE  = longint'(1) << Q_BITS;

    function automatic logic [63:0] isqrt64(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 64'd0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // entry idx of the x^2.7265 table in 0.1 mph, x = idx * 32 / 2^ptb
    function automatic t_speed pwr_entry(int unsigned ptb, int unsigned idx);
        logic [63:0] root [Q_BITS+1];
        logic [63:0] y;
        logic [63:0] fr;
        logic [63:0] eu;
        logic [63:0] f;
        logic [63:0] m;
        logic [63:0] v;
        longint      s;
        longint      sn;
        longint      e;
        int          msb;
        int          k;
        int          sh;
        int          j;
        int          bb;
        if (idx == 0)
            return '0;
        root[0] = 64'd2 << Q_BITS;
        for (j = 1; j <= Q_BITS; j++)
            root[j] = isqrt64(root[j-1] << Q_BITS);
        msb = 0;
        while ((idx >> (msb + 1)) != 0)
            msb++;
        y  = (64'(idx) << Q_BITS) >> msb;
        fr = '0;
        for (bb = 0; bb < Q_BITS; bb++) begin
            y  = (y * y) >> Q_BITS;
            fr = fr << 1;
            if (y >= (64'd2 << Q_BITS)) begin
                y  = y >> 1;
                fr = fr | 64'd1;
            end
        end
        s  = longint'(msb) * PWR_ONE + longint'(fr)
             + (longint'(5) - longint'(ptb)) * PWR_ONE;
        sn = s * longint'(27265);
        if (sn >= 0)
            e = sn / 10000;
        else
            e = -((-sn + 9999) / 10000);
        eu = unsigned'(e + longint'(64) * PWR_ONE);
        k  = int'(eu >> Q_BITS) - 64;
        f  = eu & ((64'd1 << Q_BITS) - 64'd1);
        m  = 64'd1 << Q_BITS;
        for (j = 1; j <= Q_BITS; j++)
            if (f[Q_BITS-j])
                m = (m * root[j]) >> Q_BITS;
        sh = Q_BITS - k;
        if (sh > 62)
            v = '0;
        else if (sh <= 0)
            v = 64'd65535;
        else
            v = (64'd10 * m + (64'd1 << (sh - 1))) >> sh;
        if (v > 64'd65535)
            v = 64'd65535;
        return v[SPEED_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/tac_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module tac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/thermal_anemometer_conversion.sv */
// thermal anemometer conversion: temperature, wind speed, beaufort class, air condition
// depends on tac_pkg and tac_ram
`default_nettype none

// usage
//   input channel i_in_valid / o_in_ready carries one item: a thermistor and a wind
//   element sample. output channel o_out_valid / i_out_ready returns one result item
//   per input item, in order.
//   config channel i_cfg_valid / o_cfg_ready writes the zero wind offset in mV;
//   o_cfg_ready is always high, write only while no item is in flight.
// throughput and pipeline
//   one item per cycle sustained while i_out_ready stays high. an item passes the eight
//   stage pipeline, stages 1 to 7 and the output stage, with one 10x10 multiply, two
//   reciprocal multiplies, a constant multiply correction and the power table ram read.
// reset
//   offset returns to 200 mV. after reset the power table ram is filled from the
//   constant table, one entry per cycle, 2^POWER_TABLE_BITS entries (1024 by default).
//   o_in_ready stays low during the fill.
// stall
//   each stage holds while the next stage holds; bubbles close up, so up to eight
//   items sit in the pipeline while the receiver stalls.

module thermal_anemometer_conversion #(
    parameter int ADC_BITS         = 10,
    parameter int POWER_TABLE_BITS = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output      logic                      o_in_ready,
    input  wire tac_pkg::t_in_item         i_in_item,
    output      logic                      o_out_valid,
    input  wire logic                      i_out_ready,
    output      tac_pkg::t_out_item        o_out_item,
    input  wire logic                      i_cfg_valid,
    output      logic                      o_cfg_ready,
    input  wire logic [tac_pkg::CFG_W-1:0] i_cfg_data
);

    import tac_pkg::*;

    localparam int P        = POWER_TABLE_BITS;
    localparam int ROM_SIZE = 1 << P;
    localparam int NW       = ADC_BITS + 19;
    localparam int XW       = NW + P;
    localparam int YW       = P + 11;
    localparam int RW       = P + 1;
    localparam int TNW      = 29;
    localparam int MTW      = 24;
    localparam int TRW      = 15;
    localparam int TQW      = 14;

    localparam logic [SAMPLE_W-1:0] ADC_MASK =
        (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

    localparam logic signed [TNW-1:0] T_K2  = TNW'(50);
    localparam logic signed [TNW-1:0] T_K1  = TNW'(168620);
    localparam logic signed [TNW-1:0] T_K0  = TNW'(90759000);
    localparam logic signed [TNW-1:0] T_OFS = TNW'(2560000);
    localparam logic [TRW-1:0]        T_RECIP = TRW'((1 << MTW) / 625);
    localparam logic [MTW-1:0]        T_DIV   = MTW'(625);
    localparam logic signed [TEMP_W-1:0] T_BIAS = TEMP_W'(4096);

    localparam logic signed [NW-1:0] Z_K2 = NW'(6);
    localparam logic signed [NW-1:0] Z_K1 = NW'(10727);
    localparam logic signed [NW-1:0] Z_K0 = NW'(471720);
    localparam logic signed [NW-1:0] W_K  = NW'(10000);
    localparam logic signed [NW-1:0] D_K  = NW'(5);
    localparam logic signed [NW-1:0] O_K  = NW'(10);
    localparam logic [XW-1:0]        S_SAT   = XW'(1150) << P;
    localparam logic [RW-1:0]        S_RECIP = RW'((64'd1 << YW) / 1150);
    localparam logic [YW-1:0]        S_DIV   = YW'(1150);

    // config and table fill
    logic [CFG_W-1:0] r_zero_offset;
    logic [P-1:0]     r_fill_addr;
    logic             r_fill_done;
    t_speed           w_rom [ROM_SIZE];

    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
        localparam t_speed ENTRY = pwr_entry(POWER_TABLE_BITS, g);
        assign w_rom[g] = ENTRY;
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= ZERO_OFFSET_RST;
            r_fill_addr   <= '0;
            r_fill_done   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_zero_offset <= i_cfg_data;
            end
            if (!r_fill_done) begin
                if (r_fill_addr == {P{1'b1}}) begin
                    r_fill_done <= 1'b1;
                end else begin
                    r_fill_addr <= r_fill_addr + 1'b1;
                end
            end
        end
    end

    // stage valids and ready chain
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld, r_out_vld;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6, w_rdy7, w_rdy_out;

    assign w_rdy_out = !r_out_vld || i_out_ready;
    assign w_rdy7    = !r_s7_vld  || w_rdy_out;
    assign w_rdy6    = !r_s6_vld  || w_rdy7;
    assign w_rdy5    = !r_s5_vld  || w_rdy6;
    assign w_rdy4    = !r_s4_vld  || w_rdy5;
    assign w_rdy3    = !r_s3_vld  || w_rdy4;
    assign w_rdy2    = !r_s2_vld  || w_rdy3;
    assign w_rdy1    = !r_s1_vld  || w_rdy2;
    assign o_in_ready = w_rdy1 && r_fill_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_rdy1)    r_s1_vld  <= i_in_valid && r_fill_done;
            if (w_rdy2)    r_s2_vld  <= r_s1_vld;
            if (w_rdy3)    r_s3_vld  <= r_s2_vld;
            if (w_rdy4)    r_s4_vld  <= r_s3_vld;
            if (w_rdy5)    r_s5_vld  <= r_s4_vld;
            if (w_rdy6)    r_s6_vld  <= r_s5_vld;
            if (w_rdy7)    r_s7_vld  <= r_s6_vld;
            if (w_rdy_out) r_out_vld <= r_s7_vld;
        end
    end

    // stage 1: samples and t squared
    logic [SAMPLE_W-1:0]   n_s1_t, n_s1_w, r_s1_t, r_s1_w;
    logic [2*SAMPLE_W-1:0] n_s1_tt, r_s1_tt;

    assign n_s1_t  = i_in_item.therm_sample & ADC_MASK;
    assign n_s1_w  = i_in_item.wind_sample & ADC_MASK;
    assign n_s1_tt = (2*SAMPLE_W)'(n_s1_t) * (2*SAMPLE_W)'(n_s1_t);

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_t  <= n_s1_t;
            r_s1_w  <= n_s1_w;
            r_s1_tt <= n_s1_tt;
        end
    end

    // stage 2: temperature numerator and wind difference
    logic signed [TNW-1:0] n_s2_nt, r_s2_nt;
    logic signed [NW-1:0]  n_s2_n, r_s2_n;
    logic signed [TNW-1:0] w_tt_t, w_t_t;
    logic signed [NW-1:0]  w_tt_n, w_t_n, w_w_n, w_off_n;

    assign w_tt_t  = $signed(TNW'(r_s1_tt));
    assign w_t_t   = $signed(TNW'(r_s1_t));
    assign n_s2_nt = T_K2 * w_tt_t - T_K1 * w_t_t + T_K0;

    assign w_tt_n  = $signed(NW'(r_s1_tt));
    assign w_t_n   = $signed(NW'(r_s1_t));
    assign w_w_n   = $signed(NW'(r_s1_w));
    assign w_off_n = $signed(NW'(r_zero_offset));
    assign n_s2_n  = D_K * (W_K * w_w_n - (Z_K1 * w_t_n + Z_K0 - Z_K2 * w_tt_n))
                     + ((O_K * w_off_n) <<< ADC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_nt <= n_s2_nt;
            r_s2_n  <= n_s2_n;
        end
    end

    // stage 3: dividends scaled for the reciprocal multiplies
    logic signed [TNW-1:0] w_mt_sum;
    logic [MTW-1:0]        n_s3_mt, r_s3_mt;
    logic [XW-1:0]         w_x, w_y_full;
    logic [YW-1:0]         n_s3_y, r_s3_y;
    logic                  n_s3_neg, r_s3_neg, n_s3_sat, r_s3_sat;

    assign w_mt_sum = (r_s2_nt >>> 4) + T_OFS;
    assign n_s3_mt  = w_mt_sum[MTW-1:0];
    assign n_s3_neg = r_s2_n[NW-1];
    assign w_x      = XW'($unsigned(r_s2_n)) << P;
    assign w_y_full = w_x >> (ADC_BITS + 6);
    assign n_s3_sat = w_y_full >= S_SAT;
    assign n_s3_y   = w_y_full[YW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_mt  <= n_s3_mt;
            r_s3_y   <= n_s3_y;
            r_s3_neg <= n_s3_neg;
            r_s3_sat <= n_s3_sat;
        end
    end

    // stage 4: reciprocal products
    logic [MTW+TRW-1:0] r_s4_pt;
    logic [YW+RW-1:0]   r_s4_ps;
    logic [MTW-1:0]     r_s4_mt;
    logic [YW-1:0]      r_s4_y;
    logic               r_s4_neg, r_s4_sat;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4_pt  <= (MTW+TRW)'(r_s3_mt) * (MTW+TRW)'(T_RECIP);
            r_s4_ps  <= (YW+RW)'(r_s3_y) * (YW+RW)'(S_RECIP);
            r_s4_mt  <= r_s3_mt;
            r_s4_y   <= r_s3_y;
            r_s4_neg <= r_s3_neg;
            r_s4_sat <= r_s3_sat;
        end
    end

    // stage 5: quotient estimates and back products
    logic [TQW-1:0] n_s5_q0t, r_s5_q0t;
    logic [P-1:0]   n_s5_q0s, r_s5_q0s;
    logic [MTW-1:0] r_s5_ct, r_s5_mt;
    logic [YW-1:0]  r_s5_cs, r_s5_y;
    logic           r_s5_neg, r_s5_sat;

    assign n_s5_q0t = r_s4_pt[MTW +: TQW];
    assign n_s5_q0s = r_s4_ps[YW +: P];

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_s5_q0t <= n_s5_q0t;
            r_s5_ct  <= MTW'(n_s5_q0t) * T_DIV;
            r_s5_q0s <= n_s5_q0s;
            r_s5_cs  <= YW'(n_s5_q0s) * S_DIV;
            r_s5_mt  <= r_s4_mt;
            r_s5_y   <= r_s4_y;
            r_s5_neg <= r_s4_neg;
            r_s5_sat <= r_s4_sat;
        end
    end

    // stage 6: corrected quotients, temperature and table index
    logic [MTW-1:0]           w_rem_t;
    logic [YW-1:0]            w_rem_s;
    logic [TQW-1:0]           w_qt;
    logic [P-1:0]             w_qs;
    logic signed [TEMP_W-1:0] n_s6_temp, r_s6_temp;
    logic [P-1:0]             n_s6_idx, r_s6_idx;
    logic                     r_s6_zero;

    assign w_rem_t   = r_s5_mt - r_s5_ct;
    assign w_qt      = r_s5_q0t + TQW'(w_rem_t >= T_DIV);
    assign n_s6_temp = $signed(TEMP_W'(w_qt)) - T_BIAS;
    assign w_rem_s   = r_s5_y - r_s5_cs;
    assign w_qs      = r_s5_q0s + P'(w_rem_s >= S_DIV);
    assign n_s6_idx  = r_s5_sat ? {P{1'b1}} : w_qs;

    always_ff @(posedge i_clk) begin
        if (w_rdy6) begin
            r_s6_temp <= n_s6_temp;
            r_s6_idx  <= n_s6_idx;
            r_s6_zero <= r_s5_neg;
        end
    end

    // stage 7: power table read
    t_speed                   w_ram_rdata;
    logic signed [TEMP_W-1:0] r_s7_temp;
    logic                     r_s7_zero;

    tac_ram #(
        .WIDTH (SPEED_W),
        .DEPTH (ROM_SIZE)
    ) u_pwr_ram (
        .i_clk   (i_clk),
        .i_we    (!r_fill_done),
        .i_waddr (r_fill_addr),
        .i_wdata (w_rom[r_fill_addr]),
        .i_re    (w_rdy7),
        .i_raddr (r_s6_idx),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy7) begin
            r_s7_temp <= r_s6_temp;
            r_s7_zero <= r_s6_zero;
        end
    end

    // output stage: speed and classes
    t_speed             n_out_spd;
    logic [CLASS_W-1:0] n_out_cls;
    logic [AIR_W-1:0]   n_out_air;
    t_out_item          r_out_item;

    assign n_out_spd = r_s7_zero ? '0 : w_ram_rdata;

    always_comb begin
        n_out_cls = '0;
        if (n_out_spd >= BF_CALM) begin
            n_out_cls = CLASS_W'(1);
            for (int j = 0; j < BF_N; j++) begin
                if (n_out_spd > BF_BOUND[j]) begin
                    n_out_cls = CLASS_W'(j + 2);
                end
            end
        end
    end

    always_comb begin
        priority if (n_out_spd < AIR_LIM_GOOD) begin
            n_out_air = AIR_GOOD;
        end else if (n_out_spd < AIR_LIM_NORMAL) begin
            n_out_air = AIR_NORMAL;
        end else if (n_out_spd < AIR_LIM_BAD) begin
            n_out_air = AIR_BAD;
        end else begin
            n_out_air = AIR_VERY_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_out_item.temp_centi      <= r_s7_temp;
            r_out_item.speed_tenth_mph <= n_out_spd;
            r_out_item.beaufort_class  <= n_out_cls;
            r_out_item.air_condition   <= n_out_air;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // checks
    a_fill_stays_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_done |=> r_fill_done)
        else $error("power table fill restarted");

    a_ram_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s7_vld && !w_rdy7) |=> $stable(w_ram_rdata))
        else $error("table read data changed under a stalled item");

    a_calm_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.speed_tenth_mph < BF_CALM)
                         == (o_out_item.beaufort_class == '0)))
        else $error("beaufort class disagrees with calm speed");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.beaufort_class <= CLASS_W'(BF_N + 1)))
        else $error("beaufort class out of range");

endmodule

`default_nettype wire

/* test/testbench.sv */
// self-checking testbench for thermal_anemometer_conversion
// predicts each result item from the sample pair and the zero offset it was accepted under
// depends on tac_pkg and the block under test, nothing else
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tac_pkg::*;

    localparam int     PHASES      = 8;
    localparam int     RAND_ITEMS  = 194;
    localparam int     STALL_LIMIT = 5000;
    localparam int     TABLE_SIZE  = 1024;
    localparam longint QONE        = longint'(1) << 30;

    localparam int DIR_N = 22;
    localparam int DIR_THERM [DIR_N] = '{
        0, 0, 1023, 1023, 341, 682, 1, 1022, 512, 512, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 600
    };
    localparam int DIR_WIND [DIR_N] = '{
        0, 1023, 0, 1023, 682, 341, 1, 1022, 0, 1023, 6,
        7, 30, 54, 60, 80, 100, 130, 160, 200, 300, 400
    };
    localparam int GUST_BOUND [11] = '{30, 70, 120, 170, 240, 300, 380, 460, 540, 630, 720};

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            in_valid    = 1'b0;
    t_in_item        in_item     = '0;
    logic            out_ready   = 1'b0;
    logic            cfg_valid   = 1'b0;
    logic [CFG_W-1:0] cfg_data   = '0;
    logic            in_ready;
    logic            out_valid;
    logic            cfg_ready;
    t_out_item       out_item;

    t_speed          speed_table [TABLE_SIZE];
    logic [CFG_W-1:0] zero_offset = ZERO_OFFSET_RST;
    t_in_item        samples_to_send [$];
    t_out_item       expected_readings [$];

    int errors       = 0;
    int results_seen = 0;
    int items_queued = 0;
    int calm_count   = 0;
    int pegged_count = 0;
    logic [15:0] classes_seen = '0;
    logic [3:0]  air_seen     = '0;

    int gap_left   = 0;
    int burst_left = 0;
    int rx_mode    = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    int idle_count = 0;

    thermal_anemometer_conversion dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // x^2.7265 table in 0.1 mph, entry i stands for x = i / 32
    initial begin : speed_table_init
        logic [63:0] root [31];
        logic [63:0] rad;
        logic [63:0] cand;
        logic [63:0] y;
        logic [63:0] fr;
        logic [63:0] m;
        logic [63:0] v;
        longint      s;
        longint      sn;
        longint      e;
        int          msb;
        int          k;
        int          sh;
        int          j;
        int          b;
        int          i;
        root[0] = 64'd2 << 30;
        for (j = 1; j <= 30; j++) begin
            rad = root[j-1] << 30;
            root[j] = '0;
            for (b = 31; b >= 0; b--) begin
                cand = root[j] | (64'd1 << b);
                if (cand * cand <= rad)
                    root[j] = cand;
            end
        end
        speed_table[0] = '0;
        for (i = 1; i < TABLE_SIZE; i++) begin
            msb = 0;
            while ((i >> (msb + 1)) != 0)
                msb++;
            y  = (64'(i) << 30) >> msb;
            fr = '0;
            for (b = 0; b < 30; b++) begin
                y  = (y * y) >> 30;
                fr = fr << 1;
                if (y >= (64'd2 << 30)) begin
                    y  = y >> 1;
                    fr = fr | 64'd1;
                end
            end
            s  = longint'(msb) * QONE + longint'(fr) - 5 * QONE;
            sn = s * 27265;
            e  = sn / 10000;
            if (sn < 0 && sn % 10000 != 0)
                e = e - 1;
            k = int'(e >>> 30);
            m = 64'd1 << 30;
            for (j = 1; j <= 30; j++)
                if (e[30-j])
                    m = (m * root[j]) >> 30;
            sh = 30 - k;
            if (sh > 62)
                v = '0;
            else if (sh <= 0)
                v = 64'd65535;
            else
                v = (64'd10 * m + (64'd1 << (sh - 1))) >> sh;
            if (v > 64'd65535)
                v = 64'd65535;
            speed_table[i] = v[15:0];
        end
    end

    function automatic t_out_item convert_sample(t_in_item smp, logic [CFG_W-1:0] offset_mv);
        t_out_item r;
        longint    t;
        longint    w;
        longint    raw;
        longint    temp;
        longint    zw;
        longint    n;
        longint    idx;
        longint    ms;
        int        spd;
        int        cls;
        t   = longint'(smp.therm_sample);
        w   = longint'(smp.wind_sample);
        raw = 50 * t * t - 168620 * t + 90754000 + 5000;
        temp = raw / 10000;
        if (raw < 0 && raw % 10000 != 0)
            temp = temp - 1;
        if (temp < -16384)
            temp = -16384;
        if (temp > 16383)
            temp = 16383;
        zw = -6 * t * t + 10727 * t + 471720;
        n  = (w * 10000 - zw) * 5 + longint'(offset_mv) * 10 * 1024;
        // negative difference reads as no wind
        if (n < 0) begin
            spd = 0;
        end else begin
            idx = n / 73600;
            if (idx > TABLE_SIZE - 1)
                idx = TABLE_SIZE - 1;
            spd = int'(speed_table[idx]);
        end
        if (spd < 10) begin
            cls = 0;
        end else begin
            cls = 1;
            foreach (GUST_BOUND[j])
                if (spd > GUST_BOUND[j])
                    cls++;
        end
        ms = longint'(spd) * 44704;
        if (ms < 500000)
            r.air_condition = AIR_GOOD;
        else if (ms < 1000000)
            r.air_condition = AIR_NORMAL;
        else if (ms < 1500000)
            r.air_condition = AIR_BAD;
        else
            r.air_condition = AIR_VERY_BAD;
        r.temp_centi      = temp[TEMP_W-1:0];
        r.speed_tenth_mph = spd[SPEED_W-1:0];
        r.beaufort_class  = cls[CLASS_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || in_valid || expected_readings.size() != 0
               || results_seen < items_queued)
            @(posedge i_clk);
    endtask

    // sender: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (in_valid && in_ready)
            expected_readings.push_back(convert_sample(in_item, zero_offset));
        if (!in_valid || in_ready) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (samples_to_send.size() != 0) begin
                in_item  <= samples_to_send.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall behavior switches between modes every so often
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            mode_left <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (hold_left == 0) begin
                    out_ready <= !out_ready;
                    hold_left <= $urandom_range(0, 20);
                end else begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (out_valid && out_ready) begin
            results_seen++;
            if (expected_readings.size() == 0) begin
                flag_mismatch("unexpected result item", longint'(out_item), 0);
            end else begin
                want = expected_readings.pop_front();
                if (out_item.temp_centi !== want.temp_centi)
                    flag_mismatch("temp_centi", longint'(out_item.temp_centi),
                                  longint'(want.temp_centi));
                if (out_item.speed_tenth_mph !== want.speed_tenth_mph)
                    flag_mismatch("speed_tenth_mph", longint'(out_item.speed_tenth_mph),
                                  longint'(want.speed_tenth_mph));
                if (out_item.beaufort_class !== want.beaufort_class)
                    flag_mismatch("beaufort_class", longint'(out_item.beaufort_class),
                                  longint'(want.beaufort_class));
                if (out_item.air_condition !== want.air_condition)
                    flag_mismatch("air_condition", longint'(out_item.air_condition),
                                  longint'(want.air_condition));
                if (want.speed_tenth_mph == 0)
                    calm_count++;
                if (want.speed_tenth_mph == 16'hFFFF)
                    pegged_count++;
                classes_seen[want.beaufort_class] = 1'b1;
                air_seen[want.air_condition]      = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAIL thermal_anemometer_conversion");
            $finish;
        end
    end

    initial begin
        t_in_item         smp;
        logic [CFG_W-1:0] offset_val;
        int               t;
        int               w;
        int               base;
        int               p;
        int               n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                case (p)
                    1: offset_val = '0;
                    2: offset_val = '1;
                    3: offset_val = 10'd1000;
                    4: offset_val = ZERO_OFFSET_RST;
                    default: offset_val = CFG_W'($urandom_range(0, 1023));
                endcase
                @(posedge i_clk);
                cfg_valid <= 1'b1;
                cfg_data  <= offset_val;
                do
                    @(posedge i_clk);
                while (!cfg_ready);
                cfg_valid   <= 1'b0;
                zero_offset = offset_val;
            end else begin
                for (n = 0; n < DIR_N; n++) begin
                    smp.therm_sample = SAMPLE_W'(DIR_THERM[n]);
                    smp.wind_sample  = SAMPLE_W'(DIR_WIND[n]);
                    samples_to_send.push_back(smp);
                    items_queued++;
                end
            end
            for (n = 0; n < RAND_ITEMS; n++) begin
                t = $urandom_range(0, 1023);
                case ($urandom_range(0, 9))
                    0: w = $urandom_range(0, 1) ? 1023 : 0;
                    1, 2, 3, 4: w = $urandom_range(0, 1023);
                    default: begin
                        // around the zero-wind level, where the classes change
                        base = (-6 * t * t + 10727 * t + 471720) / 10000
                               - int'(zero_offset) * 2048 / 10000;
                        w = base + $urandom_range(0, 280) - 15;
                        if (w < 0)
                            w = 0;
                        if (w > 1023)
                            w = 1023;
                    end
                endcase
                smp.therm_sample = SAMPLE_W'(t);
                smp.wind_sample  = SAMPLE_W'(w);
                samples_to_send.push_back(smp);
                items_queued++;
            end
            wait_drained();
            repeat (10) @(posedge i_clk);
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("%0d result items over %0d offset settings, %0d at zero speed, %0d saturated",
                 results_seen, PHASES, calm_count, pegged_count);
        $display("beaufort classes seen %b, air conditions seen %b", classes_seen[12:0], air_seen);
        if (errors == 0)
            $display("PASS thermal_anemometer_conversion");
        else
            $display("FAIL thermal_anemometer_conversion");
        $finish;
    end

endmodule

/* thermal_anemometer_conversion.f */
src/tac_pkg.sv
src/tac_ram.sv
src/thermal_anemometer_conversion.sv
test/testbench.sv
